### src/integer_to_padded_text_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer formatter
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_PADDED_TEXT_TOP_ASSERT_SVH
`define INTEGER_TO_PADDED_TEXT_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ITPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ITPT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### src/itpt_pkg.sv
// ----------------------------------------------------------------------------
// itpt_pkg
// Types, constants and helper functions shared by the integer formatter.
// ----------------------------------------------------------------------------
package itpt_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int VALUE_BITS_DEF = 64;

   // Fixed field widths of the channels.
   localparam int FIELD_WIDTH_W = 7;
   localparam int CHAR_W        = 8;

   // Depth of the queue between the front and the back; a power of two.
   localparam int QUEUE_DEPTH = 2;

   // ASCII characters used in the formatted text.
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // Digit characters, index 0 in the most significant byte.
   localparam logic [16*CHAR_W-1:0] DIGIT_CHARS = "0123456789abcdef";

   // Base select codes on the request channel; the spare code reads as hex.
   localparam logic [1:0] BSEL_OCT   = 2'd0;
   localparam logic [1:0] BSEL_DEC   = 2'd1;
   localparam logic [1:0] BSEL_HEX   = 2'd2;
   localparam logic [1:0] BSEL_SPARE = 2'd3;

   // Radix after classification; an unused base code is taken as hexadecimal.
   typedef enum logic [1:0] {
      RADIX_OCT = 2'd0,
      RADIX_DEC = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   // Format descriptor carried with each magnitude through the queue.
   typedef struct packed {
      radix_type                radix;
      logic                     has_sign;
      logic [CHAR_W-1:0]        sign_char;
      logic                     left;
      logic                     zpad;
      logic [FIELD_WIDTH_W-1:0] width;
   } fmt_type;

   // Returns the ASCII character of one digit value.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      return DIGIT_CHARS[CHAR_W*(15-int'(d)) +: CHAR_W];
   endfunction

endpackage

### src/itpt_channels.sv
// ----------------------------------------------------------------------------
// itpt channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: one value to format per beat.
interface itpt_req_if;
   logic                               valid;
   logic                               ready;
   logic [63:0]                        value_bits;
   logic                               treat_unsigned;
   logic [1:0]                         base_select;
   logic                               flush_left;
   logic                               force_plus;
   logic                               space_sign;
   logic                               zero_pad;
   logic [itpt_pkg::FIELD_WIDTH_W-1:0] field_width;

   modport source (
      output valid, value_bits, treat_unsigned, base_select, flush_left,
             force_plus, space_sign, zero_pad, field_width,
      input  ready
   );
   modport sink (
      input  valid, value_bits, treat_unsigned, base_select, flush_left,
             force_plus, space_sign, zero_pad, field_width,
      output ready
   );
endinterface

// Response channel: one character per beat.
interface itpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [itpt_pkg::CHAR_W-1:0] out_char;
   logic                        last_char;
   logic                        width_overflowed;

   modport source (
      output valid, out_char, last_char, width_overflowed,
      input  ready
   );
   modport sink (
      input  valid, out_char, last_char, width_overflowed,
      output ready
   );
endinterface

### src/itpt_front.sv
// ----------------------------------------------------------------------------
// itpt_front
// Accepts request beats, works out sign, magnitude, radix and width.
// ----------------------------------------------------------------------------
module itpt_front #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = itpt_pkg::MAX_WIDTH_DEF
) (
   itpt_req_if.sink                req,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic [VALUE_BITS-1:0]   push_mag,
   output itpt_pkg::fmt_type       push_fmt
);
   import itpt_pkg::*;

   logic [VALUE_BITS-1:0] raw;
   logic                  negative;

   // The front holds nothing itself: a beat moves straight into the queue.
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   // Sign and magnitude of the value.
   assign raw      = req.value_bits[VALUE_BITS-1:0];
   assign negative = !req.treat_unsigned && raw[VALUE_BITS-1];
   assign push_mag = negative ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

   // Format descriptor.
   always_comb begin
      case (req.base_select)
         BSEL_OCT: push_fmt.radix = RADIX_OCT;
         BSEL_DEC: push_fmt.radix = RADIX_DEC;
         default:  push_fmt.radix = RADIX_HEX;
      endcase

      if (negative) begin
         push_fmt.sign_char = CH_MINUS;
      end else if (req.force_plus) begin
         push_fmt.sign_char = CH_PLUS;
      end else begin
         push_fmt.sign_char = CH_SPACE;
      end
      push_fmt.has_sign = negative || req.force_plus || req.space_sign;

      push_fmt.left = req.flush_left;
      push_fmt.zpad = req.zero_pad;

      // The width saturates at the largest field the block supports.
      if (req.field_width > FIELD_WIDTH_W'(MAX_WIDTH)) begin
         push_fmt.width = FIELD_WIDTH_W'(MAX_WIDTH);
      end else begin
         push_fmt.width = req.field_width;
      end
   end

endmodule

### src/itpt_queue.sv
// ----------------------------------------------------------------------------
// itpt_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module itpt_queue #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [VALUE_BITS-1:0] push_mag,
   input  itpt_pkg::fmt_type     push_fmt,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [VALUE_BITS-1:0] pop_mag,
   output itpt_pkg::fmt_type     pop_fmt
);
   import itpt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [VALUE_BITS-1:0] mag_mem_ff [QUEUE_DEPTH];
   fmt_type               fmt_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_mag    = mag_mem_ff[rd_ptr_ff];
   assign pop_fmt    = fmt_mem_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap naturally.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, written on a push.
   always_ff @(posedge clock) begin
      if (push) begin
         mag_mem_ff[wr_ptr_ff] <= push_mag;
         fmt_mem_ff[wr_ptr_ff] <= push_fmt;
      end
   end

endmodule

### src/itpt_back.sv
// ----------------------------------------------------------------------------
// itpt_back
// Converts a magnitude to digits and emits the padded text, one beat a char.
// ----------------------------------------------------------------------------
`include "integer_to_padded_text_top_assert.svh"

module itpt_back #(
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = itpt_pkg::MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [VALUE_BITS-1:0] pop_mag,
   input  itpt_pkg::fmt_type     pop_fmt,
   itpt_rsp_if.source            rsp
);
   import itpt_pkg::*;

   // Octal needs the most digits; decimal and hexadecimal fit in as many.
   localparam int NDIG       = (VALUE_BITS + 2) / 3;
   localparam int DIG_BITS   = 4 * NDIG;
   localparam int CONV_BITS  = VALUE_BITS + (VALUE_BITS % 2);
   localparam int CONV_STEPS = CONV_BITS / 2;
   localparam int STEP_W     = $clog2(CONV_STEPS);
   localparam int ND_W       = $clog2(NDIG + 1);
   localparam int DIG_IDX_W  = $clog2(NDIG);
   localparam int LEN_W      = $clog2(MAX_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [CONV_BITS-1:0]  mag_ff, mag_in;
   logic [DIG_BITS-1:0]   bcd_ff, bcd_in;
   fmt_type               fmt_ff, fmt_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  ovf_ff, ovf_in;
   logic [LEN_W-1:0]      dig_lo_ff, dig_lo_in;
   logic [LEN_W-1:0]      dig_hi_ff, dig_hi_in;
   logic [LEN_W-1:0]      sign_pos_ff, sign_pos_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic [DIG_BITS-1:0]   mag_ext;
   logic [DIG_BITS-1:0]   oct_digits;
   logic [DIG_BITS-1:0]   dd_bcd;
   logic [CONV_BITS-1:0]  dd_mag;
   logic [ND_W-1:0]       nd_calc;
   logic [LEN_W-1:0]      total, width_sat, len_calc, sign_len;
   logic                  ovf_calc;
   logic [LEN_W-1:0]      dig_off;
   logic [DIG_IDX_W-1:0]  dig_idx;
   logic [CHAR_W-1:0]     char_sel;
   logic                  emit_fire, emit_last;

   assign pop_ready = (state_ff == ST_IDLE);

   // Octal digits split out of the magnitude; hexadecimal digits are the
   // magnitude itself.
   assign mag_ext = {{(DIG_BITS - VALUE_BITS){1'b0}}, pop_mag};
   always_comb begin
      oct_digits = '0;
      for (int i = 0; i < NDIG; i++) begin
         oct_digits[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
      end
   end

   // Two shift-and-add-three steps of the binary to BCD conversion.
   always_comb begin
      dd_bcd = bcd_ff;
      dd_mag = mag_ff;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < NDIG; i++) begin
            if (dd_bcd[4*i +: 4] >= 4'd5) begin
               dd_bcd[4*i +: 4] = dd_bcd[4*i +: 4] + 4'd3;
            end
         end
         dd_bcd = {dd_bcd[DIG_BITS-2:0], dd_mag[CONV_BITS-1]};
         dd_mag = {dd_mag[CONV_BITS-2:0], 1'b0};
      end
   end

   // Digit count (at least one), text length and overflow decision.
   always_comb begin
      nd_calc = ND_W'(1);
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            nd_calc = ND_W'(i + 1);
         end
      end
      sign_len  = LEN_W'(fmt_ff.has_sign);
      total     = LEN_W'(nd_calc) + sign_len;
      width_sat = LEN_W'(fmt_ff.width);
      ovf_calc  = (width_sat != '0) && (total > width_sat);
      if (ovf_calc) begin
         len_calc = width_sat;
      end else if (total > width_sat) begin
         len_calc = total;
      end else begin
         len_calc = width_sat;
      end
   end

   // Character at the current output position.
   assign dig_off = dig_hi_ff - pos_ff - LEN_W'(1);
   assign dig_idx = dig_off[DIG_IDX_W-1:0];
   always_comb begin
      if (ovf_ff) begin
         char_sel = CH_HASH;
      end else if (fmt_ff.has_sign && (pos_ff == sign_pos_ff)) begin
         char_sel = fmt_ff.sign_char;
      end else if ((pos_ff >= dig_lo_ff) && (pos_ff < dig_hi_ff)) begin
         char_sel = digit_char(bcd_ff[4*dig_idx +: 4]);
      end else if (!fmt_ff.left && fmt_ff.zpad) begin
         char_sel = CH_ZERO;
      end else begin
         char_sel = CH_SPACE;
      end
   end

   assign emit_fire = (state_ff == ST_EMIT) && (!out_valid_ff || rsp.ready);
   assign emit_last = (pos_ff == len_ff - LEN_W'(1));

   // Sequencer: take an item, convert, size the field, emit characters.
   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      fmt_in      = fmt_ff;
      step_in     = step_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      dig_lo_in   = dig_lo_ff;
      dig_hi_in   = dig_hi_ff;
      sign_pos_in = sign_pos_ff;
      pos_in      = pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               fmt_in  = pop_fmt;
               mag_in  = {{(CONV_BITS - VALUE_BITS){1'b0}}, pop_mag};
               step_in = '0;
               case (pop_fmt.radix)
                  RADIX_DEC: begin
                     bcd_in   = '0;
                     state_in = ST_CONV;
                  end
                  RADIX_OCT: begin
                     bcd_in   = oct_digits;
                     state_in = ST_SIZE;
                  end
                  default: begin
                     bcd_in   = mag_ext;
                     state_in = ST_SIZE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            bcd_in  = dd_bcd;
            mag_in  = dd_mag;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            len_in = len_calc;
            ovf_in = ovf_calc;
            pos_in = '0;
            if (fmt_ff.left) begin
               dig_lo_in   = sign_len;
               dig_hi_in   = sign_len + LEN_W'(nd_calc);
               sign_pos_in = '0;
            end else begin
               dig_lo_in   = len_calc - LEN_W'(nd_calc);
               dig_hi_in   = len_calc;
               sign_pos_in = fmt_ff.zpad ? '0 : len_calc - LEN_W'(nd_calc) - LEN_W'(1);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + LEN_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: holds a beat until the sink takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_char_in  = char_sel;
         out_last_in  = emit_last;
         out_ovf_in   = ovf_ff;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.out_char         = out_char_ff;
   assign rsp.last_char        = out_last_ff;
   assign rsp.width_overflowed = out_ovf_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      fmt_ff      <= fmt_in;
      step_ff     <= step_in;
      len_ff      <= len_in;
      ovf_ff      <= ovf_in;
      dig_lo_ff   <= dig_lo_in;
      dig_hi_ff   <= dig_hi_in;
      sign_pos_ff <= sign_pos_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // The output position never runs past the field length.
   `ITPT_ASSERT(a_pos_in_field, (state_ff == ST_EMIT) |-> (pos_ff < len_ff), "position past field")
   // The final character returns the sequencer to idle and is marked.
   `ITPT_ASSERT_NEXT(a_last_to_idle, emit_fire && emit_last, (state_ff == ST_IDLE) && out_last_ff, "last beat lost")
   // Only decimal items go through the BCD conversion.
   `ITPT_ASSERT(a_conv_decimal, (state_ff == ST_CONV) |-> (fmt_ff.radix == RADIX_DEC), "conversion on non-decimal")
   // An overflowed field is made of hashes only.
   `ITPT_ASSERT(a_ovf_hash, (out_valid_ff && out_ovf_ff) |-> (out_char_ff == CH_HASH), "overflow without hash")
   // Taking an item always starts work on it.
   `ITPT_ASSERT_NEXT(a_pop_starts, pop_valid && pop_ready, state_ff != ST_IDLE, "item taken but idle")

endmodule

### src/integer_to_padded_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_padded_text_top
// Formats integers as padded ASCII text in octal, decimal or hexadecimal.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Beat                         Handshake
//  req_chan   in         one value with format flags  valid/ready
//  rsp_chan   out        one character, last marked   valid/ready
//
// The back part handles one item at a time: it takes the item, runs the BCD
// conversion (two bits a cycle) for decimal only, sizes the field, then emits
// one character per cycle while the output is not stalled.
// The front accepts into a two-entry queue while the back is busy.
// Reset is synchronous and clears the queue, the sequencer and the output.
// A stalled output beat holds in the output register and pauses emission.
//
module integer_to_padded_text_top #(
   parameter int MAX_WIDTH  = itpt_pkg::MAX_WIDTH_DEF,
   parameter int VALUE_BITS = itpt_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   itpt_req_if.sink    req_chan,
   itpt_rsp_if.source  rsp_chan
);
   import itpt_pkg::*;

   logic                  push_valid, push_ready;
   logic [VALUE_BITS-1:0] push_mag;
   fmt_type               push_fmt;
   logic                  pop_valid, pop_ready;
   logic [VALUE_BITS-1:0] pop_mag;
   fmt_type               pop_fmt;

   // Front: classification of each request beat.
   itpt_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_mag   (push_mag),
      .push_fmt   (push_fmt)
   );

   // Queue between the two parts.
   itpt_queue #(
      .VALUE_BITS (VALUE_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_mag   (push_mag),
      .push_fmt   (push_fmt),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_mag    (pop_mag),
      .pop_fmt    (pop_fmt)
   );

   // Back: conversion and character emission.
   itpt_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_mag   (pop_mag),
      .pop_fmt   (pop_fmt),
      .rsp       (rsp_chan)
   );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for integer_to_padded_text_top
// Sends directed values, then values with random format flags and widths, through
// the request channel, predicts the padded ASCII text of each accepted value, and checks
// every response beat against the oldest predicted character in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itpt_pkg::*;

   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_VALUES = 480;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int HOLDOFF_LEN   = 400;
   localparam int MAX_REPORTS   = 10;
   localparam int MAX_CHARS     = 64;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      STALL_NONE   = 2'd0,
      STALL_COIN   = 2'd1,
      STALL_SPARSE = 2'd2,
      STALL_LIGHT  = 2'd3
   } stall_mode_type;

   // One value to format, as carried by a request beat.
   typedef struct packed {
      logic [63:0]              value;
      logic                     treat_unsigned;
      logic [1:0]               base_select;
      logic                     flush_left;
      logic                     force_plus;
      logic                     space_sign;
      logic                     zero_pad;
      logic [FIELD_WIDTH_W-1:0] field_width;
   } text_req_type;

   // One predicted character, as carried by a response beat.
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_char;
      logic              width_overflowed;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itpt_req_if req_chan ();
   itpt_rsp_if rsp_chan ();

   text_req_type   pending_values [$];
   text_char_type  expected_chars [$];

   int             error_count    = 0;
   int             cycle_count    = 0;
   int             received_chars = 0;
   int             burst_left     = 1;
   int             gap_left       = 0;
   logic           offer_next;
   stall_mode_type stall_mode     = STALL_NONE;
   int             mode_left      = 0;
   int             sparse_phase   = 0;
   int             holdoff_left   = 0;
   int             holdoffs_done  = 0;
   logic           ready_next;
   text_char_type  got_char;

   integer_to_padded_text_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock of 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Builds one request.
   function automatic text_req_type make_req(input logic [63:0] value, input logic uns,
                                             input logic [1:0] bsel, input logic left,
                                             input logic plus, input logic space,
                                             input logic zpad, input int width);
      text_req_type r;
      r.value          = value;
      r.treat_unsigned = uns;
      r.base_select    = bsel;
      r.flush_left     = left;
      r.force_plus     = plus;
      r.space_sign     = space;
      r.zero_pad       = zpad;
      r.field_width    = width[FIELD_WIDTH_W-1:0];
      return r;
   endfunction

   // Random request: value drawn from several classes, widths mostly small.
   function automatic text_req_type random_req();
      logic [63:0] value;
      int          width;
      case ($urandom_range(0, 7))
         0:       value = {$urandom(), $urandom()};
         1:       value = 64'($urandom_range(0, 20));
         2:       value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         3:       value = ~64'($urandom_range(0, 300)) + 64'd1;
         4:       value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3))
                          - 64'($urandom_range(0, 3));
         5:       value = {64{1'b1}} - 64'($urandom_range(0, 2));
         6:       value = 64'($urandom_range(0, 99999));
         default: value = {{32{1'b0}}, $urandom()};
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4:  width = 0;
         16, 17:         width = $urandom_range(25, MAX_CHARS);
         18, 19:         width = $urandom_range(MAX_CHARS + 1, 127);
         default:        width = $urandom_range(1, 24);
      endcase
      return make_req(value, 1'($urandom()), 2'($urandom_range(0, 3)), 1'($urandom()),
                      1'($urandom()), 1'($urandom()), 1'($urandom()), width);
   endfunction

   // Works out the text of one accepted value and queues its characters.
   function automatic void format_text(input text_req_type r);
      logic [63:0]       mag;
      logic [63:0]       radix;
      logic [63:0]       digit;
      logic [CHAR_W-1:0] digits [0:23];
      logic [CHAR_W-1:0] text_buf [0:MAX_CHARS-1];
      logic [CHAR_W-1:0] sign_char;
      logic              negative;
      logic              has_sign;
      logic              overflow;
      int                nd;
      int                width;
      int                total;
      int                pad;
      int                n;
      text_char_type     c;

      nd        = 0;
      n         = 0;
      pad       = 0;
      overflow  = 1'b0;
      sign_char = CH_SPACE;
      width     = (int'(r.field_width) > MAX_CHARS) ? MAX_CHARS : int'(r.field_width);
      radix     = (r.base_select == BSEL_OCT) ? 64'd8 :
                  (r.base_select == BSEL_DEC) ? 64'd10 : 64'd16;

      // Magnitude of a negative signed value.
      negative = !r.treat_unsigned && r.value[63];
      mag      = negative ? (~r.value + 64'd1) : r.value;

      // Digits, least significant first; zero prints as one digit.
      while (mag != 0 && nd < 24) begin
         digit      = mag % radix;
         digits[nd] = (digit < 10) ? (CH_ZERO + CHAR_W'(digit))
                                   : (8'h61 + CHAR_W'(digit - 10));
         mag        = mag / radix;
         nd++;
      end
      if (nd == 0) begin
         digits[0] = CH_ZERO;
         nd        = 1;
      end

      // A minus wins over the plus and space flags.
      has_sign = 1'b1;
      if (negative) begin
         sign_char = CH_MINUS;
      end else if (r.force_plus) begin
         sign_char = CH_PLUS;
      end else if (r.space_sign) begin
         sign_char = CH_SPACE;
      end else begin
         has_sign = 1'b0;
      end
      total = nd + (has_sign ? 1 : 0);

      if (width > 0 && total > width) begin
         // The text does not fit: the whole field is hashes.
         overflow = 1'b1;
         for (int i = 0; i < width; i++) text_buf[n++] = CH_HASH;
      end else begin
         if (width > 0) pad = width - total;
         if (r.flush_left) begin
            if (has_sign) text_buf[n++] = sign_char;
            for (int i = nd - 1; i >= 0; i--) text_buf[n++] = digits[i];
            for (int i = 0; i < pad; i++) text_buf[n++] = CH_SPACE;
         end else begin
            if (r.zero_pad) begin
               if (has_sign) text_buf[n++] = sign_char;
               for (int i = 0; i < pad; i++) text_buf[n++] = CH_ZERO;
            end else begin
               for (int i = 0; i < pad; i++) text_buf[n++] = CH_SPACE;
               if (has_sign) text_buf[n++] = sign_char;
            end
            for (int i = nd - 1; i >= 0; i--) text_buf[n++] = digits[i];
         end
      end

      for (int i = 0; i < n; i++) begin
         c.out_char         = text_buf[i];
         c.last_char        = (i == n - 1);
         c.width_overflowed = overflow;
         expected_chars.push_back(c);
      end
   endfunction

   // Driver: offers queued values in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         offer_next = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            format_text(pending_values.pop_front());
            offer_next = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!offer_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_values.size() != 0) begin
               offer_next              = 1'b1;
               req_chan.value_bits     <= pending_values[0].value;
               req_chan.treat_unsigned <= pending_values[0].treat_unsigned;
               req_chan.base_select    <= pending_values[0].base_select;
               req_chan.flush_left     <= pending_values[0].flush_left;
               req_chan.force_plus     <= pending_values[0].force_plus;
               req_chan.space_sign     <= pending_values[0].space_sign;
               req_chan.zero_pad       <= pending_values[0].zero_pad;
               req_chan.field_width    <= pending_values[0].field_width;
            end
         end
         req_chan.valid <= offer_next;
      end
   end

   // Monitor: checks each response beat and drives ready on its own pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_char.out_char         = rsp_chan.out_char;
            got_char.last_char        = rsp_chan.last_char;
            got_char.width_overflowed = rsp_chan.width_overflowed;
            received_chars++;
            if (expected_chars.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: unexpected beat char=%h last=%b ovf=%b", $realtime,
                           got_char.out_char, got_char.last_char,
                           got_char.width_overflowed);
               error_count++;
            end else if (got_char !== expected_chars[0]) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: expected char=%h last=%b ovf=%b, got %h %b %b",
                           $realtime, expected_chars[0].out_char,
                           expected_chars[0].last_char, expected_chars[0].width_overflowed,
                           got_char.out_char, got_char.last_char,
                           got_char.width_overflowed);
               error_count++;
               void'(expected_chars.pop_front());
            end else begin
               void'(expected_chars.pop_front());
            end
         end

         // Two long hold-offs let the block fill up and stall its input.
         if (holdoffs_done == 0 && received_chars >= 200 ||
             holdoffs_done == 1 && received_chars >= 2500) begin
            holdoff_left = HOLDOFF_LEN;
            holdoffs_done++;
         end

         if (holdoff_left > 0) begin
            holdoff_left--;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            sparse_phase = (sparse_phase + 1) % 4;
            case (stall_mode)
               STALL_NONE:   ready_next = 1'b1;
               STALL_COIN:   ready_next = 1'($urandom());
               STALL_SPARSE: ready_next = (sparse_phase == 0);
               default:      ready_next = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_chan.ready <= ready_next;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      req_chan.valid          = 1'b0;
      req_chan.value_bits     = '0;
      req_chan.treat_unsigned = 1'b0;
      req_chan.base_select    = BSEL_OCT;
      req_chan.flush_left     = 1'b0;
      req_chan.force_plus     = 1'b0;
      req_chan.space_sign     = 1'b0;
      req_chan.zero_pad       = 1'b0;
      req_chan.field_width    = '0;
      rsp_chan.ready          = 1'b0;

      // Directed values: zero, the extremes, each flag and the width cases.
      pending_values.push_back(make_req(64'd0, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'd0, 1'b1, BSEL_OCT, 1'b0, 1'b1, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'd0, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b1, 1'b0, 4));
      pending_values.push_back(make_req({64{1'b1}}, 1'b1, BSEL_OCT, 1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req({64{1'b1}}, 1'b1, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req({64{1'b1}}, 1'b1, BSEL_HEX, 1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req({64{1'b1}}, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'h8000_0000_0000_0000, 1'b0, BSEL_DEC,
                                        1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'h8000_0000_0000_0000, 1'b0, BSEL_OCT,
                                        1'b0, 1'b1, 1'b0, 1'b1, 30));
      pending_values.push_back(make_req(64'h7fff_ffff_ffff_ffff, 1'b0, BSEL_HEX,
                                        1'b0, 1'b1, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'd42, 1'b0, BSEL_DEC, 1'b1, 1'b1, 1'b0, 1'b0, 10));
      pending_values.push_back(make_req(-64'sd42, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b1, 12));
      pending_values.push_back(make_req(-64'sd42, 1'b0, BSEL_DEC, 1'b1, 1'b0, 1'b0, 1'b1, 12));
      pending_values.push_back(make_req(64'd255, 1'b1, BSEL_HEX, 1'b0, 1'b0, 1'b0, 1'b0, 8));
      pending_values.push_back(make_req(64'd255, 1'b1, BSEL_HEX, 1'b0, 1'b0, 1'b1, 1'b1, 8));
      pending_values.push_back(make_req(64'd12345, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 3));
      pending_values.push_back(make_req(64'd12345, 1'b0, BSEL_DEC, 1'b0, 1'b1, 1'b0, 1'b0, 6));
      pending_values.push_back(make_req(64'd12345, 1'b0, BSEL_DEC, 1'b0, 1'b1, 1'b0, 1'b0, 5));
      pending_values.push_back(make_req(-64'sd5, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1));
      pending_values.push_back(make_req(64'hdead_beef, 1'b1, BSEL_SPARE,
                                        1'b0, 1'b0, 1'b0, 1'b0, 0));
      pending_values.push_back(make_req(64'd7, 1'b1, BSEL_OCT, 1'b1, 1'b0, 1'b0, 1'b0, 127));
      pending_values.push_back(make_req(64'd7, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b1, 64));
      pending_values.push_back(make_req(-64'sd7, 1'b0, BSEL_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 65));
      pending_values.push_back(make_req({64{1'b1}}, 1'b1, BSEL_OCT, 1'b0, 1'b0, 1'b0, 1'b0, 21));

      for (int i = 0; i < RANDOM_VALUES; i++) pending_values.push_back(random_req());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_chan.valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/itpt_pkg.sv
src/itpt_channels.sv
src/itpt_front.sv
src/itpt_queue.sv
src/itpt_back.sv
src/integer_to_padded_text_top.sv
sim/tb.sv
